// ===== rtl/feature_track_table_occupancy_top_macros.svh =====
// assertion macros for the track table checker
// expects clk and rst_n in the scope of use
`ifndef FEATURE_TRACK_TABLE_OCCUPANCY_TOP_MACROS_SVH
`define FEATURE_TRACK_TABLE_OCCUPANCY_TOP_MACROS_SVH

// same-cycle implication
`define FTTO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftto check failed");

// next-cycle implication
`define FTTO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftto check failed");

`endif

// ===== rtl/ftto_pkg.sv =====
// shared types, codes and default sizes of the track table
// no dependencies
`timescale 1ns / 1ps

package ftto_pkg;

    localparam int TRACKS_DEF       = 256;
    localparam int HISTORY_DEF      = 16;
    localparam int LAG_DEF          = 3;
    localparam int STILL_WINDOW_DEF = 5;
    localparam int MAP_ENTRIES_DEF  = 524288;

    localparam logic [2:0] FN_OPEN   = 3'd0;
    localparam logic [2:0] FN_APPEND = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_CHECK  = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;
    localparam logic [2:0] FN_BIND   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STILL  = 2'd2;

    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam logic [19:0] STILL_RST  = 20'd16;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         track_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [23:0]        frame_number;
        logic               bound_flag;
    } item_t;

    typedef struct packed {
        logic        keep;
        logic        replaced_valid;
        logic [7:0]  replaced_track;
        logic [1:0]  status;
        logic [4:0]  track_length;
        logic [23:0] start_frame;
    } result_t;

endpackage

// ===== rtl/feature_track_table_occupancy_top.sv =====
// Track table with bounded position history and an occupancy map with one entry per 16x16
// block of positions. One item is taken at a time; the input stalls while it is worked. Open,
// append, remove, bind and unknown codes go through a slot record read, an update and the
// result register. A check on a long track reads the cur and lag positions one after the
// other through the single read port of the history ram, then sums one stored velocity per
// cycle in the accumulator, then the pixel index goes through one multiplier and the occupancy
// ram is read and, when the track takes the cell, written, with one more slot record read
// for an occupant. Clear map sweeps the occupancy ram one entry a cycle over all MAP_ENTRIES
// entries. After reset the same clearing pass runs before the first item is taken; config
// writes are taken at all times. The result register lets the next item in while a result
// still waits.
// depends on ftto_pkg and ftto_ram
`timescale 1ns / 1ps

module feature_track_table_occupancy_top #(
    parameter int TRACKS       = ftto_pkg::TRACKS_DEF,
    parameter int HISTORY      = ftto_pkg::HISTORY_DEF,
    parameter int LAG          = ftto_pkg::LAG_DEF,
    parameter int STILL_WINDOW = ftto_pkg::STILL_WINDOW_DEF,
    parameter int MAP_ENTRIES  = ftto_pkg::MAP_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ftto_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ftto_pkg::result_t result,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data
);

    import ftto_pkg::*;

    localparam int SW  = $clog2(TRACKS);
    localparam int HW  = $clog2(HISTORY);
    localparam int LW  = $clog2(HISTORY + 1);
    localparam int CW  = $clog2(TRACKS + 1);
    localparam int PW  = $clog2(TRACKS * HISTORY);
    localparam int MW  = $clog2(MAP_ENTRIES);
    localparam int OW  = SW + 1;
    localparam int MTW = 1 + HW + LW + 24;
    localparam int KW  = $clog2(STILL_WINDOW) + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_META  = 4'd2;
    localparam logic [3:0] S_PRE   = 4'd3;
    localparam logic [3:0] S_VEL   = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_STILL = 4'd6;
    localparam logic [3:0] S_PIX   = 4'd7;
    localparam logic [3:0] S_IDX   = 4'd8;
    localparam logic [3:0] S_OCC   = 4'd9;
    localparam logic [3:0] S_OMETA = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    function automatic logic [HW-1:0] ring(input logic [HW-1:0] h, input logic [LW-1:0] k);
        logic [LW:0] s;
        s = (LW+1)'(h) + (LW+1)'(k);
        if (s >= (LW+1)'(HISTORY))
        begin
            s = s - (LW+1)'(HISTORY);
        end
        return HW'(s);
    endfunction

    function automatic logic [PW-1:0] paddr(input logic [SW-1:0] t, input logic [HW-1:0] r);
        return PW'(PW'(t) * PW'(HISTORY) + PW'(r));
    endfunction

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    // control state
    logic [3:0]        state_reg, state_next;
    logic [TRACKS-1:0] used_reg, used_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              clr_rep_reg, clr_rep_next;
    logic              result_valid_reg, result_valid_next;
    logic [11:0]       width_reg, height_reg;
    logic [19:0]       still_reg;

    // payload
    item_t             item_reg, item_next;
    result_t           res_reg, res_next;
    result_t           result_reg, result_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [HW-1:0]     head_reg, head_next;
    logic              bound_reg, bound_next;
    logic signed [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [20:0]       acc_reg, acc_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [22:0]       idx_reg, idx_next;
    logic [SW-1:0]     o_reg, o_next;

    // ram ports
    logic              meta_we, meta_re;
    logic [SW-1:0]     meta_wa, meta_ra;
    logic [MTW-1:0]    meta_wd, meta_rd;
    logic              pos_we, pos_re;
    logic [PW-1:0]     pos_wa, pos_ra;
    logic [31:0]       pos_wd, pos_rd;
    logic              vel_we, vel_re;
    logic [PW-1:0]     vel_wa, vel_ra;
    logic [33:0]       vel_wd, vel_rd;
    logic              occ_we, occ_re;
    logic [MW-1:0]     occ_wa, occ_ra;
    logic [OW-1:0]     occ_wd, occ_rd;

    ftto_ram #(.WIDTH(MTW), .DEPTH(TRACKS)) u_meta_ram (
        .clk(clk), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
        .rd_en(meta_re), .rd_addr(meta_ra), .rd_data(meta_rd)
    );

    ftto_ram #(.WIDTH(32), .DEPTH(TRACKS * HISTORY)) u_pos_ram (
        .clk(clk), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
        .rd_en(pos_re), .rd_addr(pos_ra), .rd_data(pos_rd)
    );

    ftto_ram #(.WIDTH(34), .DEPTH(TRACKS * HISTORY)) u_vel_ram (
        .clk(clk), .wr_en(vel_we), .wr_addr(vel_wa), .wr_data(vel_wd),
        .rd_en(vel_re), .rd_addr(vel_ra), .rd_data(vel_rd)
    );

    ftto_ram #(.WIDTH(OW), .DEPTH(MAP_ENTRIES)) u_occ_ram (
        .clk(clk), .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
        .rd_en(occ_re), .rd_addr(occ_ra), .rd_data(occ_rd)
    );

    always_comb
    begin
        logic [SW-1:0]      tslot;
        logic               in_range;
        logic               ok;
        logic               m_bound;
        logic [HW-1:0]      m_head;
        logic [LW-1:0]      m_len;
        logic [23:0]        m_frame;
        logic [HW-1:0]      h2;
        logic [LW-1:0]      l2;
        logic [23:0]        f2;
        logic signed [16:0] vx, vy, sx, sy;
        logic [11:0]        px, py;
        logic               off;
        logic [SW-1:0]      os;

        tslot    = SW'(item_reg.track_id);
        in_range = (32'(item_reg.track_id) < TRACKS);
        ok       = in_range && used_reg[tslot];
        m_bound  = meta_rd[MTW-1];
        m_head   = meta_rd[MTW-2 -: HW];
        m_len    = meta_rd[LW+23:24];
        m_frame  = meta_rd[23:0];
        h2       = m_head;
        l2       = m_len;
        f2       = m_frame;
        vx       = 17'(cur_x_reg) - 17'($signed(pos_rd[15:0]));
        vy       = 17'(cur_y_reg) - 17'($signed(pos_rd[15:0]));
        sx       = 17'(cur_x_reg) + 17'sd8;
        sy       = 17'(cur_y_reg) + 17'sd8;
        px       = sx[16] ? 12'd0 : sx[15:4];
        py       = sy[16] ? 12'd0 : sy[15:4];
        off      = 1'b0;
        os       = occ_rd[SW-1:0];

        state_next   = state_reg;
        used_next    = used_reg;
        count_next   = count_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_rep_next = clr_rep_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        result_next  = result_reg;
        len_next     = len_reg;
        head_next    = head_reg;
        bound_next   = bound_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        acc_next     = acc_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        o_next       = o_reg;
        result_valid_next = result_valid_reg && result_stall;

        meta_we = 1'b0;
        meta_wa = tslot;
        meta_wd = '0;
        meta_re = 1'b0;
        meta_ra = tslot;
        pos_we  = 1'b0;
        pos_wa  = '0;
        pos_wd  = {item_reg.pos_x, item_reg.pos_y};
        pos_re  = 1'b0;
        pos_ra  = '0;
        vel_we  = 1'b0;
        vel_wa  = '0;
        vel_wd  = '0;
        vel_re  = 1'b0;
        vel_ra  = '0;
        occ_we  = 1'b0;
        occ_wa  = MW'(idx_reg);
        occ_wd  = {1'b1, tslot};
        occ_re  = 1'b0;
        occ_ra  = MW'(idx_reg);

        case (state_reg)
            S_CLEAR:
            begin
                occ_we = 1'b1;
                occ_wa = clr_cnt_reg;
                occ_wd = '0;
                if (clr_cnt_reg == MW'(MAP_ENTRIES - 1))
                begin
                    state_next = clr_rep_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    res_next   = '0;
                    meta_re    = 1'b1;
                    meta_ra    = SW'(item.track_id);
                    state_next = S_META;
                end
            end
            S_META:
            begin
                len_next   = m_len;
                head_next  = m_head;
                bound_next = m_bound;
                state_next = S_EMIT;
                case (item_reg.func)
                    FN_OPEN:
                    begin
                        if (!in_range)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else if (!used_reg[tslot] && count_reg >= CW'(TRACKS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            if (!used_reg[tslot])
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            used_next[tslot] = 1'b1;
                            meta_we = 1'b1;
                            meta_wd = {1'b0, HW'(0), LW'(1), item_reg.frame_number};
                            pos_we  = 1'b1;
                            pos_wa  = paddr(tslot, HW'(0));
                            vel_we  = 1'b1;
                            vel_wa  = paddr(tslot, HW'(0));
                            res_next.track_length = 5'd1;
                            res_next.start_frame  = item_reg.frame_number;
                        end
                    end
                    FN_APPEND:
                    begin
                        if (!ok)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            if (32'(m_len) >= HISTORY)
                            begin
                                h2 = ring(m_head, LW'(HISTORY - HISTORY / 2));
                                f2 = m_frame + 24'(HISTORY - HISTORY / 2);
                                l2 = LW'(HISTORY / 2);
                            end
                            meta_we = 1'b1;
                            meta_wd = {m_bound, h2, LW'(l2 + 1'b1), f2};
                            pos_we  = 1'b1;
                            pos_wa  = paddr(tslot, ring(h2, l2));
                            vel_we  = 1'b1;
                            vel_wa  = paddr(tslot, ring(h2, l2));
                            res_next.track_length = 5'(l2 + 1'b1);
                            res_next.start_frame  = f2;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (!ok)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            used_next[tslot] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    FN_BIND:
                    begin
                        if (!ok)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            meta_we = 1'b1;
                            meta_wd = {item_reg.bound_flag, m_head, m_len, m_frame};
                            res_next.track_length = 5'(m_len);
                            res_next.start_frame  = m_frame;
                        end
                    end
                    FN_CLEAR:
                    begin
                        clr_cnt_next = '0;
                        clr_rep_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    FN_CHECK:
                    begin
                        if (!ok)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            res_next.track_length = 5'(m_len);
                            res_next.start_frame  = m_frame;
                            if (32'(m_len) < LAG)
                            begin
                                res_next.keep = 1'b1;
                            end
                            else
                            begin
                                pos_re     = 1'b1;
                                pos_ra     = paddr(tslot, ring(m_head, m_len - 1'b1));
                                state_next = S_PRE;
                            end
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_PRE:
            begin
                cur_x_next = $signed(pos_rd[31:16]);
                cur_y_next = $signed(pos_rd[15:0]);
                pos_re     = 1'b1;
                pos_ra     = paddr(tslot, ring(head_reg, len_reg - LW'(LAG)));
                state_next = S_VEL;
            end
            S_VEL:
            begin
                vx = 17'(cur_x_reg) - 17'($signed(pos_rd[31:16]));
                vy = 17'(cur_y_reg) - 17'($signed(pos_rd[15:0]));
                vel_we   = 1'b1;
                vel_wa   = paddr(tslot, ring(head_reg, len_reg - 1'b1));
                vel_wd   = {vx, vy};
                acc_next = 21'(abs17(vx)) + 21'(abs17(vy));
                if (32'(len_reg) > STILL_WINDOW)
                begin
                    if (STILL_WINDOW > 1)
                    begin
                        vel_re     = 1'b1;
                        vel_ra     = paddr(tslot, ring(head_reg, len_reg - LW'(2)));
                        k_next     = KW'(1);
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_STILL;
                    end
                end
                else
                begin
                    state_next = S_PIX;
                end
            end
            S_SUM:
            begin
                vx = $signed(vel_rd[33:17]);
                vy = $signed(vel_rd[16:0]);
                acc_next = acc_reg + 21'(abs17(vx)) + 21'(abs17(vy));
                if (k_reg == KW'(STILL_WINDOW - 1))
                begin
                    state_next = S_STILL;
                end
                else
                begin
                    vel_re = 1'b1;
                    vel_ra = paddr(tslot, ring(head_reg, len_reg - LW'(k_reg) - LW'(2)));
                    k_next = k_reg + 1'b1;
                end
            end
            S_STILL:
            begin
                if (acc_reg < {1'b0, still_reg} && !bound_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_PIX;
                end
            end
            S_PIX:
            begin
                off = (sx < -17'sd15) || (sy < -17'sd15) || (px >= width_reg)
                      || (py >= height_reg);
                idx_next = 23'(py) * 23'(width_reg) + 23'(px);
                state_next = off ? S_EMIT : S_IDX;
            end
            S_IDX:
            begin
                if (32'(idx_reg) >= MAP_ENTRIES)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    occ_re     = 1'b1;
                    state_next = S_OCC;
                end
            end
            S_OCC:
            begin
                if (!occ_rd[OW-1] || !used_reg[os])
                begin
                    occ_we        = 1'b1;
                    res_next.keep = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    meta_re    = 1'b1;
                    meta_ra    = os;
                    o_next     = os;
                    state_next = S_OMETA;
                end
            end
            S_OMETA:
            begin
                state_next = S_EMIT;
                if (!m_bound)
                begin
                    res_next.keep = 1'b1;
                end
                else if (bound_reg && m_len < len_reg)
                begin
                    occ_we = 1'b1;
                    res_next.keep           = 1'b1;
                    res_next.replaced_valid = 1'b1;
                    res_next.replaced_track = 8'(o_reg);
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    clr_rep_next      = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            used_reg         <= '0;
            count_reg        <= '0;
            clr_cnt_reg      <= '0;
            clr_rep_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            width_reg        <= WIDTH_RST;
            height_reg       <= HEIGHT_RST;
            still_reg        <= STILL_RST;
        end
        else
        begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            count_reg        <= count_next;
            clr_cnt_reg      <= clr_cnt_next;
            clr_rep_reg      <= clr_rep_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data[11:0];
                    CFG_HEIGHT: height_reg <= cfg_data[11:0];
                    CFG_STILL:  still_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        result_reg <= result_next;
        len_reg    <= len_next;
        head_reg   <= head_next;
        bound_reg  <= bound_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        acc_reg    <= acc_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        o_reg      <= o_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/ftto_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ftto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ftto_checker.sv =====
// port-level checks of the track table, bound to the top level
// depends on ftto_pkg and feature_track_table_occupancy_top_macros.svh
`timescale 1ns / 1ps
`include "feature_track_table_occupancy_top_macros.svh"

module ftto_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input ftto_pkg::result_t result
);

    import ftto_pkg::*;

    // one item at a time
    `FTTO_ASSERT_NEXT(a_busy_after_beat, item_valid && !item_stall, item_stall)
    `FTTO_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
    // a displacement always keeps the checked track
    `FTTO_ASSERT_NOW(a_replace_keeps, result_valid && result.replaced_valid, result.keep && result.status == ST_OK)
    // an error beat carries nothing else
    `FTTO_ASSERT_NOW(a_error_clean, result_valid && result.status != ST_OK, !result.keep && !result.replaced_valid && result.track_length == 5'd0 && result.start_frame == 24'd0)

endmodule

bind feature_track_table_occupancy_top ftto_checker u_ftto_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
);
